FILE: src/monochrome_bitmap_blitter_unit_macros.svh
// Assertion macros for the checker file.
`ifndef MONOCHROME_BITMAP_BLITTER_UNIT_MACROS_SVH
`define MONOCHROME_BITMAP_BLITTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BMB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BMB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bmb_pkg.sv
`default_nettype none

package bmb_pkg;

    // Panel geometry and framebuffer layout
    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_SIZE   = PANEL_WIDTH * PAGE_COUNT;
    localparam int ADDR_W       = $clog2(STORE_SIZE);
    localparam int PAGE_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    // Pixel steps per bitmap byte
    localparam int BYTE_BITS = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BMP_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BMP_HEIGHT = 2'd3;

    // Command codes
    localparam logic CMD_BITMAP = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_RCAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [8:0] dest_x;
        logic [8:0] dest_y;
        logic [7:0] bmp_width;
        logic [7:0] bmp_height;
    } cfg_t;

    // Everything the address unit needs for one pixel step
    typedef struct packed {
        logic [8:0]        dest_x;
        logic [7:0]        bmp_width;
        logic [4:0]        byte_column;
        logic [2:0]        bit_idx;
        logic [7:0]        pixels;
        logic              row_ok;
        logic [ADDR_W-1:0] page_base;
    } step_ctx_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } pix_t;

endpackage

`default_nettype wire

FILE: src/bmb_ram.sv
`default_nettype none

module bmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/bmb_addr_unit.sv
`default_nettype none

module bmb_addr_unit import bmb_pkg::*; (
    input  wire step_ctx_t ctx,
    output pix_t           pix
);

    logic [7:0] xx;
    logic [9:0] px;
    logic       col_ok;

    // Bitmap column of this bit, then panel column
    assign xx = {ctx.byte_column, 3'b000} + {5'b00000, ctx.bit_idx};
    assign px = {ctx.dest_x[8], ctx.dest_x} + {2'b00, xx};

    // Clip against bitmap width and panel width
    assign col_ok = !px[9] && (px < 10'(PANEL_WIDTH));

    assign pix.hit  = ctx.pixels[ctx.bit_idx] && (xx < ctx.bmp_width) && col_ok && ctx.row_ok;
    assign pix.addr = ctx.page_base + ADDR_W'(px);

endmodule

`default_nettype wire

FILE: src/bmb_seq.sv
`default_nettype none

module bmb_seq import bmb_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              cmd,
    input  wire logic [7:0]        pixel_byte,
    input  wire logic [9:0]        read_addr,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [7:0]        read_data,
    output logic                   bitmap_done,
    output step_ctx_t              ctx,
    input  wire pix_t              pix,
    output logic                   wr_en,
    output logic      [ADDR_W-1:0] wr_addr,
    output logic      [7:0]        wr_data,
    output logic                   rd_en,
    output logic      [ADDR_W-1:0] rd_addr,
    input  wire logic [7:0]        rd_data
);

    // Control state
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [3:0]        step_reg, step_next;
    logic [4:0]        byte_column_reg, byte_column_next;
    logic [7:0]        pixel_row_reg, pixel_row_next;
    logic              out_valid_reg, out_valid_next;

    // Payload
    logic [7:0]        pixels_reg, pixels_next;
    logic              row_ok_reg, row_ok_next;
    logic [ADDR_W-1:0] page_base_reg, page_base_next;
    logic [7:0]        mask_reg, mask_next;
    logic              prev_hit_reg, prev_hit_next;
    logic [ADDR_W-1:0] prev_addr_reg, prev_addr_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [7:0]        res_data_reg, res_data_next;
    logic              res_done_reg, res_done_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_done_reg, out_done_next;

    logic              accept;
    logic [9:0]        py;
    logic [PAGE_W-1:0] page;
    logic [5:0]        row_bytes;
    logic [5:0]        col_inc;
    logic [8:0]        row_inc;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign read_data   = out_data_reg;
    assign bitmap_done = out_done_reg;

    // Panel row of the current bitmap row and its page
    assign py   = {cfg.dest_y[8], cfg.dest_y} + {2'b00, pixel_row_reg};
    assign page = py[PAGE_W+2:3];

    // Cursor arithmetic
    assign row_bytes = 6'(({1'b0, cfg.bmp_width} + 9'd7) >> 3);
    assign col_inc   = {1'b0, byte_column_reg} + 6'd1;
    assign row_inc   = {1'b0, pixel_row_reg} + 9'd1;

    // Step context for the address unit
    always_comb
    begin
        ctx.dest_x      = cfg.dest_x;
        ctx.bmp_width   = cfg.bmp_width;
        ctx.byte_column = byte_column_reg;
        ctx.bit_idx     = step_reg[2:0];
        ctx.pixels      = pixels_reg;
        ctx.row_ok      = row_ok_reg;
        ctx.page_base   = page_base_reg;
    end

    // Next state and memory control
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        step_next        = step_reg;
        byte_column_next = byte_column_reg;
        pixel_row_next   = pixel_row_reg;
        out_valid_next   = out_valid_reg;
        pixels_next      = pixels_reg;
        row_ok_next      = row_ok_reg;
        page_base_next   = page_base_reg;
        mask_next        = mask_reg;
        prev_hit_next    = prev_hit_reg;
        prev_addr_next   = prev_addr_reg;
        rd_addr_next     = rd_addr_reg;
        rd_ok_next       = rd_ok_reg;
        res_data_next    = res_data_reg;
        res_done_next    = res_done_reg;
        out_data_next    = out_data_reg;
        out_done_next    = out_done_reg;
        wr_en            = 1'b0;
        wr_addr          = prev_addr_reg;
        wr_data          = rd_data | mask_reg;
        rd_en            = 1'b0;
        rd_addr          = pix.addr;

        // Drop the output once it is transferred
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = 8'd0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(STORE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_READ)
                    begin
                        rd_addr_next = ADDR_W'(read_addr);
                        rd_ok_next   = {22'd0, read_addr} < 32'(STORE_SIZE);
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        pixels_next    = pixel_byte;
                        row_ok_next    = !py[9] && (py < 10'(PANEL_HEIGHT));
                        page_base_next = ADDR_W'(int'(page) * PANEL_WIDTH);
                        mask_next      = 8'd1 << py[2:0];
                        step_next      = 4'd0;
                        state_next     = ST_DRAW;
                    end
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = rd_addr_reg;
                state_next = ST_RCAP;
            end
            ST_RCAP:
            begin
                res_data_next = rd_ok_reg ? rd_data : 8'd0;
                res_done_next = 1'b0;
                state_next    = ST_DONE;
            end
            ST_DRAW:
            begin
                // Read the byte for this bit, write back the previous one
                if (!step_reg[3])
                begin
                    rd_en          = 1'b1;
                    prev_hit_next  = pix.hit;
                    prev_addr_next = pix.addr;
                end
                if ((step_reg != 4'd0) && prev_hit_reg)
                begin
                    wr_en = 1'b1;
                end
                step_next = step_reg + 4'd1;

                // Last write-back done: advance the bitmap cursor
                if (step_reg == 4'(BYTE_BITS))
                begin
                    res_data_next = 8'd0;
                    res_done_next = 1'b0;
                    if (col_inc >= row_bytes)
                    begin
                        byte_column_next = 5'd0;
                        if (row_inc >= {1'b0, cfg.bmp_height})
                        begin
                            pixel_row_next = 8'd0;
                            res_done_next  = 1'b1;
                        end
                        else
                        begin
                            pixel_row_next = row_inc[7:0];
                        end
                    end
                    else
                    begin
                        byte_column_next = col_inc[4:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data_reg;
                    out_done_next  = res_done_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            step_reg        <= 4'd0;
            byte_column_reg <= 5'd0;
            pixel_row_reg   <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            step_reg        <= step_next;
            byte_column_reg <= byte_column_next;
            pixel_row_reg   <= pixel_row_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pixels_reg    <= pixels_next;
        row_ok_reg    <= row_ok_next;
        page_base_reg <= page_base_next;
        mask_reg      <= mask_next;
        prev_hit_reg  <= prev_hit_next;
        prev_addr_reg <= prev_addr_next;
        rd_addr_reg   <= rd_addr_next;
        rd_ok_reg     <= rd_ok_next;
        res_data_reg  <= res_data_next;
        res_done_reg  <= res_done_next;
        out_data_reg  <= out_data_next;
        out_done_reg  <= out_done_next;
    end

endmodule

`default_nettype wire

FILE: src/monochrome_bitmap_blitter_unit.sv
// Channel   Handshake            Payload
// --------  -------------------  ----------------------------------
// input     in_valid / in_stall  cmd, pixel_byte, read_addr
// output    out_valid/out_stall  read_data, bitmap_done
// config    cfg_we               cfg_index, cfg_data
//
// A read passes through the READ, RCAP and DONE states before its result reaches the
// output register; a bitmap byte takes one framebuffer read-modify-write per pixel bit
// through the single RAM port pair. After reset a clearing pass zeroes all STORE_SIZE
// framebuffer bytes (1024 for a 128x64 panel); no input is taken meanwhile.
// The next input is taken while a finished result waits in the output register.
`default_nettype none

module monochrome_bitmap_blitter_unit import bmb_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [8:0]           cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cmd,
    input  wire logic [7:0]           pixel_byte,
    input  wire logic [9:0]           read_addr,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [7:0]           read_data,
    output logic                      bitmap_done
);

    cfg_t              cfg_reg;
    step_ctx_t         ctx;
    pix_t              pix;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_x     <= 9'd0;
            cfg_reg.dest_y     <= 9'd0;
            cfg_reg.bmp_width  <= 8'd8;
            cfg_reg.bmp_height <= 8'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEST_X:     cfg_reg.dest_x     <= cfg_data;
                CFG_DEST_Y:     cfg_reg.dest_y     <= cfg_data;
                CFG_BMP_WIDTH:  cfg_reg.bmp_width  <= cfg_data[7:0];
                CFG_BMP_HEIGHT: cfg_reg.bmp_height <= cfg_data[7:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    bmb_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pixel_byte  (pixel_byte),
        .read_addr   (read_addr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .bitmap_done (bitmap_done),
        .ctx         (ctx),
        .pix         (pix),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    bmb_addr_unit u_addr (
        .ctx (ctx),
        .pix (pix)
    );

    bmb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

FILE: src/bmb_checker.sv
`default_nettype none
`include "monochrome_bitmap_blitter_unit_macros.svh"

module bmb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] read_data,
    input wire logic       bitmap_done
);

    // A stalled result holds its payload
    `BMB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_data) && $stable(bitmap_done), "stalled result changed")

    // Each transfer keeps the block busy for the next cycle
    `BMB_ASSERT_NXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input taken on back-to-back cycles")

    // No result appears the cycle right after an input transfer
    `BMB_ASSERT_NXT(a_no_instant_out, in_valid && !in_stall, !$rose(out_valid), "result too early")

    // A result is either read data or a bitmap status, never both
    `BMB_ASSERT_IMP(a_result_kind, out_valid, (read_data == 8'd0) || !bitmap_done, "mixed result")

endmodule

bind monochrome_bitmap_blitter_unit bmb_checker u_bmb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .bitmap_done (bitmap_done)
);

`default_nettype wire
